@@ rtl/shsu_pkg.sv @@
// shsu_pkg: shared types and constants for the sparse hll sorted table update unit
// request and result payload structs, the internal work item and the back-end states
// no dependencies
package shsu_pkg;

  // fixed field widths of the request and result payloads
  localparam int HASH_W       = 64;
  localparam int IDX_FIELD_W  = 26;
  localparam int RANK_BITS    = 6;
  localparam int COUNT_FIELD_W = 11;

  // soft limit after reset
  localparam logic [COUNT_FIELD_W-1:0] SOFT_LIMIT_RESET = 11'd1024;

  // request command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_MERGE  = 1'b1;

  // request payload
  typedef struct packed {
    logic                   cmd;
    logic [HASH_W-1:0]      hash;
    logic [IDX_FIELD_W-1:0] entry_index;
    logic [RANK_BITS-1:0]   entry_rank;
    logic                   batch_last;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [COUNT_FIELD_W-1:0] entry_count;
    logic                     limit_reached;
    logic                     dropped;
    logic                     batch_done;
  } out_item_t;

  // classified request passed from the front end to the back end
  typedef struct packed {
    logic [IDX_FIELD_W-1:0] idx;
    logic [RANK_BITS-1:0]   rank;
    logic                   last;
  } work_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WAIT,
    ST_SHIFT,
    ST_PLACE,
    ST_REPORT
  } back_state_t;

endpackage

@@ rtl/shsu_fifo.sv @@
// shsu_fifo: small synchronous queue of packed words
// used between front end and back end and on the result side; no package use
module shsu_fifo #(
  parameter int WIDTH      = 8,
  parameter int DEPTH_LOG2 = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [WIDTH-1:0]      slots [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr;
  logic [DEPTH_LOG2-1:0] rd_ptr;
  logic [DEPTH_LOG2:0]   cnt;
  logic                  do_wr;
  logic                  do_rd;

  assign full  = (cnt == (DEPTH_LOG2+1)'(DEPTH));
  assign empty = (cnt == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + DEPTH_LOG2'(1);
      if (do_rd) rd_ptr <= rd_ptr + DEPTH_LOG2'(1);
      case ({do_wr, do_rd})
        2'b10:   cnt <= cnt + (DEPTH_LOG2+1)'(1);
        2'b01:   cnt <= cnt - (DEPTH_LOG2+1)'(1);
        default: cnt <= cnt;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

@@ rtl/shsu_front.sv @@
// shsu_front: classifies a request into a bucket index and rank
// insert requests derive both from the hash via a leading-zero count; uses shsu_pkg
module shsu_front #(
  parameter int INDEX_BITS = 26
) (
  input  shsu_pkg::in_item_t item,
  output shsu_pkg::work_t    work
);

  localparam int IdxW  = shsu_pkg::IDX_FIELD_W;
  localparam int RankW = shsu_pkg::RANK_BITS;

  // leading zeros of a nonzero byte
  function automatic logic [2:0] clz8(input logic [7:0] v);
    logic [2:0] n;
    n = 3'd7;
    for (int b = 0; b < 8; b++) begin
      if (v[b]) n = 3'(7 - b);
    end
    return n;
  endfunction

  logic [63:0]  rest;
  logic [7:0]   byte_nz;
  logic [2:0]   byte_clz [8];
  logic [5:0]   zeros;
  logic [6:0]   rank_sum;

  // bits below the index, with a stop bit right after them
  assign rest = (item.hash << INDEX_BITS) | (64'(1) << (INDEX_BITS - 1));

  // per-byte leading-zero counts
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      byte_nz[c]  = |rest[63-8*c -: 8];
      byte_clz[c] = clz8(rest[63-8*c -: 8]);
    end
  end

  // first nonzero byte sets the count
  always_comb begin
    zeros = '0;
    for (int c = 7; c >= 0; c--) begin
      if (byte_nz[c]) zeros = {3'(c), byte_clz[c]};
    end
  end

  assign rank_sum = {1'b0, zeros} + 7'd1;

  // select fields by command
  always_comb begin
    work.last = item.batch_last;
    case (item.cmd)
      shsu_pkg::CMD_INSERT: begin
        work.idx  = IdxW'(item.hash[63 -: INDEX_BITS]);
        work.rank = RankW'(rank_sum);
      end
      default: begin
        work.idx  = IdxW'(item.entry_index[INDEX_BITS-1:0]);
        work.rank = item.entry_rank;
      end
    endcase
  end

endmodule

@@ rtl/shsu_back.sv @@
// shsu_back: sorted table store and update sequencer
// binary search, max-rank update, shift-and-insert or drop, then one result; uses shsu_pkg
module shsu_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int INDEX_BITS  = 26
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  shsu_pkg::work_t     q_data,
  output logic                q_pop,
  input  logic                r_full,
  output logic                r_push,
  output shsu_pkg::out_item_t r_data,
  input  logic [shsu_pkg::COUNT_FIELD_W-1:0] soft_limit
);

  localparam int RankW = shsu_pkg::RANK_BITS;
  localparam int CntFW = shsu_pkg::COUNT_FIELD_W;
  localparam int CW    = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int EW    = INDEX_BITS + RankW;
  localparam int CmpW  = CW + CntFW;

  // table store
  logic [EW-1:0] table_mem [TABLE_DEPTH];
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) table_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= table_mem[rd_addr];
  end

  // sequencer registers
  shsu_pkg::back_state_t state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         lo, lo_next;
  logic [CW-1:0]         hi, hi_next;
  logic [AW-1:0]         mid, mid_next;
  logic [INDEX_BITS-1:0] key, key_next;
  logic [RankW-1:0]      krank, krank_next;
  logic                  klast, klast_next;
  logic                  hit, hit_next;
  logic [RankW-1:0]      hit_rank, hit_rank_next;
  logic                  drop, drop_next;
  logic [AW-1:0]         sh_idx, sh_idx_next;
  logic                  sh_more, sh_more_next;
  logic                  sh_pend, sh_pend_next;
  logic [AW-1:0]         sh_addr, sh_addr_next;

  logic [CW:0]           mid_sum;
  logic [INDEX_BITS-1:0] rd_idx;
  logic [RankW-1:0]      rd_rank;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign rd_idx  = rd_data[EW-1:RankW];
  assign rd_rank = rd_data[RankW-1:0];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= shsu_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    lo       <= lo_next;
    hi       <= hi_next;
    mid      <= mid_next;
    key      <= key_next;
    krank    <= krank_next;
    klast    <= klast_next;
    hit      <= hit_next;
    hit_rank <= hit_rank_next;
    drop     <= drop_next;
    sh_idx   <= sh_idx_next;
    sh_more  <= sh_more_next;
    sh_pend  <= sh_pend_next;
    sh_addr  <= sh_addr_next;
  end

  // result fields
  always_comb begin
    r_data.entry_count   = CntFW'(count);
    r_data.limit_reached = (CmpW'(count) >= CmpW'(soft_limit));
    r_data.dropped       = drop;
    r_data.batch_done    = klast;
  end

  // next state and store control
  always_comb begin
    state_next    = state;
    count_next    = count;
    lo_next       = lo;
    hi_next       = hi;
    mid_next      = mid;
    key_next      = key;
    krank_next    = krank;
    klast_next    = klast;
    hit_next      = hit;
    hit_rank_next = hit_rank;
    drop_next     = drop;
    sh_idx_next   = sh_idx;
    sh_more_next  = sh_more;
    sh_pend_next  = sh_pend;
    sh_addr_next  = sh_addr;
    q_pop         = 1'b0;
    r_push        = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = mid;
    wr_en         = 1'b0;
    wr_addr       = lo[AW-1:0];
    wr_data       = {key, krank};

    case (state)
      // take a request once the result side has room
      shsu_pkg::ST_IDLE: begin
        if (!q_empty && !r_full) begin
          q_pop      = 1'b1;
          key_next   = q_data.idx[INDEX_BITS-1:0];
          krank_next = q_data.rank;
          klast_next = q_data.last;
          lo_next    = '0;
          hi_next    = count;
          hit_next   = 1'b0;
          drop_next  = 1'b0;
          state_next = shsu_pkg::ST_SEARCH;
        end
      end

      // lower-bound search step, or decide once the range is empty
      shsu_pkg::ST_SEARCH: begin
        if (lo < hi) begin
          mid_next   = mid_sum[AW:1];
          rd_en      = 1'b1;
          rd_addr    = mid_sum[AW:1];
          state_next = shsu_pkg::ST_WAIT;
        end else if (hit) begin
          if (hit_rank < krank) wr_en = 1'b1;
          state_next = shsu_pkg::ST_REPORT;
        end else if (count == CW'(TABLE_DEPTH)) begin
          drop_next  = 1'b1;
          state_next = shsu_pkg::ST_REPORT;
        end else if (lo < count) begin
          sh_idx_next  = AW'(count - CW'(1));
          sh_more_next = 1'b1;
          sh_pend_next = 1'b0;
          state_next   = shsu_pkg::ST_SHIFT;
        end else begin
          state_next = shsu_pkg::ST_PLACE;
        end
      end

      // compare the probed entry and narrow the range
      shsu_pkg::ST_WAIT: begin
        if (rd_idx < key) begin
          lo_next = CW'(mid) + CW'(1);
        end else begin
          hi_next       = CW'(mid);
          hit_next      = (rd_idx == key);
          hit_rank_next = rd_rank;
        end
        state_next = shsu_pkg::ST_SEARCH;
      end

      // move entries up by one, top first, read and write overlapped
      shsu_pkg::ST_SHIFT: begin
        if (sh_pend) begin
          wr_en   = 1'b1;
          wr_addr = sh_addr + AW'(1);
          wr_data = rd_data;
        end
        if (sh_more) begin
          rd_en        = 1'b1;
          rd_addr      = sh_idx;
          sh_pend_next = 1'b1;
          sh_addr_next = sh_idx;
          if (sh_idx == lo[AW-1:0]) begin
            sh_more_next = 1'b0;
          end else begin
            sh_idx_next = sh_idx - AW'(1);
          end
        end else begin
          sh_pend_next = 1'b0;
          state_next   = shsu_pkg::ST_PLACE;
        end
      end

      // write the new entry into the opened slot
      shsu_pkg::ST_PLACE: begin
        wr_en      = 1'b1;
        count_next = count + CW'(1);
        state_next = shsu_pkg::ST_REPORT;
      end

      // hand the result over
      shsu_pkg::ST_REPORT: begin
        r_push     = 1'b1;
        state_next = shsu_pkg::ST_IDLE;
      end

      default: begin
        state_next = shsu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/sparse_hll_sorted_table_update_unit.sv @@
// sparse_hll_sorted_table_update_unit: top level of the sparse hll sorted table
// holds the soft limit register and joins front end, request queue, back end and
// result queue; uses shsu_pkg, shsu_front, shsu_fifo, shsu_back
//
// Keeps up to TABLE_DEPTH (bucket index, rank) entries sorted by index. A request
// either derives the pair from a 64-bit hash (top INDEX_BITS bits are the index,
// rank is the leading-zero count of the rest plus one) or merges a given pair; an
// existing index keeps the larger rank, a new index is inserted in order or, on a
// full table, dropped and flagged. Each request gives exactly one result. Requests
// are classified on entry and wait in a small queue; the back end then handles one
// at a time against a single-port-read table memory. Each request runs a binary
// search (each probe is a registered memory read); an index inserted below the top
// entry then moves the upper entries up by one and writes the new one, one that
// lands at the end is written directly, and a rank update or a drop skips the move.
// The result is then handed over. Results wait in a two-entry queue, so a slow
// consumer does not stall the table until it fills.
module sparse_hll_sorted_table_update_unit #(
  parameter int TABLE_DEPTH      = 1024,
  parameter int INDEX_BITS       = 26,
  parameter int QUEUE_DEPTH_LOG2 = 2
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  output logic                                   full,
  input  shsu_pkg::in_item_t                     item,
  output logic                                   empty,
  input  logic                                   pop,
  output shsu_pkg::out_item_t                    result,
  input  logic                                   cfg_we,
  input  logic [shsu_pkg::COUNT_FIELD_W-1:0]     cfg_wdata
);

  logic [shsu_pkg::COUNT_FIELD_W-1:0] soft_limit;
  shsu_pkg::work_t     work_in;
  shsu_pkg::work_t     work_out;
  logic                work_empty;
  logic                work_pop;
  shsu_pkg::out_item_t res_in;
  logic                res_push;
  logic                res_full;

  // soft limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      soft_limit <= shsu_pkg::SOFT_LIMIT_RESET;
    end else if (cfg_we) begin
      soft_limit <= cfg_wdata;
    end
  end

  // request classification
  shsu_front #(
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .item (item),
    .work (work_in)
  );

  // queue between front end and back end
  shsu_fifo #(
    .WIDTH      ($bits(shsu_pkg::work_t)),
    .DEPTH_LOG2 (QUEUE_DEPTH_LOG2)
  ) u_work_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (work_in),
    .full    (full),
    .rd_en   (work_pop),
    .rd_data (work_out),
    .empty   (work_empty)
  );

  // table update sequencer
  shsu_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .INDEX_BITS  (INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (work_empty),
    .q_data     (work_out),
    .q_pop      (work_pop),
    .r_full     (res_full),
    .r_push     (res_push),
    .r_data     (res_in),
    .soft_limit (soft_limit)
  );

  // result queue
  shsu_fifo #(
    .WIDTH      ($bits(shsu_pkg::out_item_t)),
    .DEPTH_LOG2 (1)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty)
  );

endmodule
